/* hdl/crw_pkg.sv */
// ----------------------------------------------------------------------------
// crw_pkg
// Shared types and codes for the chunk reorder window.
// ----------------------------------------------------------------------------
package crw_pkg;

	localparam int unsigned NUM_W  = 24;
	localparam int unsigned PAY_W  = 64;
	localparam int unsigned SIZE_W = 11;

	localparam logic [SIZE_W-1:0] CHUNK_SIZE_RST = 11'd1400;

	// action codes
	localparam logic ACT_STORE = 1'b0;
	localparam logic ACT_END   = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_FULL   = 2'd1;
	localparam logic [1:0] KIND_SHORT  = 2'd2;

	typedef struct packed {
		logic              action;
		logic [NUM_W-1:0]  chunk_number;
		logic [PAY_W-1:0]  payload;
		logic [SIZE_W-1:0] byte_count;
	} in_word_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic              accepted;
		logic [NUM_W-1:0]  out_number;
		logic [PAY_W-1:0]  out_payload;
		logic [SIZE_W-1:0] out_bytes;
		logic              last;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STORE,
		ST_RUN,
		ST_TAIL
	} crw_state_t;

endpackage

/* hdl/crw_ram.sv */
// ----------------------------------------------------------------------------
// crw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module crw_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/chunk_reorder_window_top.sv */
// ----------------------------------------------------------------------------
// chunk_reorder_window_top
// Receive reorder window: buffers numbered chunks and releases them in order.
// ----------------------------------------------------------------------------
// Path: start is taken in ST_IDLE and the word is decoded in ST_STORE; in ST_RUN each
//   front slot is read, passes the read stage and lands in the output register. A new
//   item is taken only once busy drops. Throughput: one released chunk per cycle, paced
//   by the single RAM read port; ST_TAIL sends a closing short chunk or status word.
// Reset: arst_n clears window base, front pointer, occupied bits, counters and
//   flags at once; the payload RAM needs no clearing pass.
// Results are strobed for one cycle on result_valid; the receiver cannot stall.
module chunk_reorder_window_top #(
	parameter int unsigned WINDOW = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  crw_pkg::in_word_t            cmd,
	output logic                         busy,
	output logic                         result_valid,
	output crw_pkg::out_word_t           result,
	input  logic                         cfg_we,
	input  logic [crw_pkg::SIZE_W-1:0]   cfg_wdata
);

	import crw_pkg::*;

	localparam int unsigned SW = $clog2(WINDOW);
	localparam int unsigned RW = $clog2(WINDOW + 1);

	crw_state_t state_q, state_d;

	// configuration
	logic [SIZE_W-1:0] chunk_size_q;

	// captured command
	in_word_t cmd_q;
	logic     acc_q;

	// window state
	logic [NUM_W-1:0]  base_q;
	logic [SW-1:0]     front_q;
	logic [WINDOW-1:0] occ_q;
	logic [RW-1:0]     held_q;
	logic [RW-1:0]     run_q;

	// short chunk holder
	logic [PAY_W-1:0]  short_pay_q;
	logic [SIZE_W-1:0] short_bytes_q;
	logic [NUM_W-1:0]  short_num_q;
	logic              short_held_q;
	logic              end_pend_q;

	// read stage
	logic             s1_valid_s1;
	logic [NUM_W-1:0] s1_number_s1;

	// tail word kind
	logic [1:0] tail_kind_q;

	// output register
	out_word_t out_q;
	logic      out_valid_q;

	// RAM port
	logic             ram_we, ram_re;
	logic [SW-1:0]    ram_waddr;
	logic [PAY_W-1:0] ram_rdata;

	// store decode
	logic [NUM_W-1:0] num_ofs;
	logic             in_win;
	logic             is_full;
	logic [SW:0]      slot_sum;
	logic [SW-1:0]    slot;

	// release decode
	logic          rel;
	logic          short_due;
	logic [SW-1:0] front_nx;

	assign num_ofs  = cmd_q.chunk_number - base_q;
	assign in_win   = num_ofs < NUM_W'(WINDOW);
	assign is_full  = cmd_q.byte_count == chunk_size_q;
	assign slot_sum = {1'b0, front_q} + {1'b0, num_ofs[SW-1:0]};
	assign slot     = (slot_sum >= (SW+1)'(WINDOW)) ?
		SW'(slot_sum - (SW+1)'(WINDOW)) : slot_sum[SW-1:0];

	assign rel       = (state_q == ST_RUN) && occ_q[front_q] && (run_q < RW'(WINDOW));
	assign short_due = (run_q < RW'(WINDOW)) && end_pend_q && (held_q == '0) && short_held_q;
	assign front_nx  = (front_q == SW'(WINDOW - 1)) ? '0 : front_q + 1'b1;

	assign ram_we    = (state_q == ST_STORE) && (cmd_q.action == ACT_STORE) && in_win && is_full;
	assign ram_waddr = slot;
	assign ram_re    = rel;

	crw_ram #(
		.WIDTH(PAY_W),
		.DEPTH(WINDOW)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(cmd_q.payload),
		.re   (ram_re),
		.raddr(front_q),
		.rdata(ram_rdata)
	);

	assign busy         = state_q != ST_IDLE;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_STORE;
			end
			ST_STORE: state_d = ST_RUN;
			ST_RUN: begin
				// leave once the front run ends; a tail word follows unless the
				// last released chunk closes the sequence
				if (!rel) begin
					state_d = (short_due || run_q == '0) ? ST_TAIL : ST_IDLE;
				end
			end
			ST_TAIL: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_size_q <= CHUNK_SIZE_RST;
		end else if (cfg_we) begin
			chunk_size_q <= cfg_wdata;
		end
	end

	// capture the command word
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= cmd;
		end
	end

	// window, holder and output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q         <= 1'b0;
			base_q        <= '0;
			front_q       <= '0;
			occ_q         <= '0;
			held_q        <= '0;
			run_q         <= '0;
			short_bytes_q <= '0;
			short_num_q   <= '0;
			short_held_q  <= 1'b0;
			end_pend_q    <= 1'b0;
			s1_valid_s1   <= 1'b0;
			tail_kind_q   <= KIND_STATUS;
			out_valid_q   <= 1'b0;
		end else begin
			// strobe a word after each read stage and on the tail
			out_valid_q <= ((state_q == ST_RUN) && s1_valid_s1) || (state_q == ST_TAIL);
			s1_valid_s1 <= rel;
			case (state_q)
				ST_STORE: begin
					run_q <= '0;
					if (cmd_q.action == ACT_END) begin
						acc_q      <= 1'b1;
						end_pend_q <= 1'b1;
					end else begin
						acc_q <= in_win;
						if (in_win && !is_full) begin
							// hold the short chunk apart; a later one overwrites it
							short_bytes_q <= cmd_q.byte_count;
							short_num_q   <= cmd_q.chunk_number;
							short_held_q  <= 1'b1;
						end else if (in_win && !occ_q[slot]) begin
							occ_q[slot] <= 1'b1;
							held_q      <= held_q + 1'b1;
						end
					end
				end
				ST_RUN: begin
					if (rel) begin
						// release the front slot and slide the window by one
						occ_q[front_q] <= 1'b0;
						held_q         <= held_q - 1'b1;
						base_q         <= base_q + 1'b1;
						front_q        <= front_nx;
						run_q          <= run_q + 1'b1;
					end else begin
						tail_kind_q <= short_due ? KIND_SHORT : KIND_STATUS;
					end
				end
				ST_TAIL: begin
					if (tail_kind_q == KIND_SHORT) begin
						short_held_q <= 1'b0;
						end_pend_q   <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload side: no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_STORE && cmd_q.action == ACT_STORE && in_win && !is_full) begin
			short_pay_q <= cmd_q.payload;
		end
		if (rel) begin
			s1_number_s1 <= base_q;
		end
		case (state_q)
			ST_RUN: begin
				if (s1_valid_s1) begin
					out_q.kind        <= KIND_FULL;
					out_q.accepted    <= acc_q;
					out_q.out_number  <= s1_number_s1;
					out_q.out_payload <= ram_rdata;
					out_q.out_bytes   <= chunk_size_q;
					out_q.last        <= !rel && !short_due;
				end
			end
			ST_TAIL: begin
				out_q.kind     <= tail_kind_q;
				out_q.accepted <= acc_q;
				out_q.last     <= 1'b1;
				if (tail_kind_q == KIND_SHORT) begin
					out_q.out_number  <= short_num_q;
					out_q.out_payload <= short_pay_q;
					out_q.out_bytes   <= short_bytes_q;
				end else begin
					out_q.out_number  <= '0;
					out_q.out_payload <= '0;
					out_q.out_bytes   <= '0;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_held_matches_occ: assert property (@(posedge clk) disable iff (!arst_n)
		32'(held_q) == $countones(occ_q))
		else $error("held count differs from occupied bits");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("slot RAM written and read in one cycle");

	a_quiet_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.last) |=> !out_valid_q)
		else $error("result word after the last one of an item");

	a_idle_no_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !s1_valid_s1)
		else $error("read stage live while idle");

	a_tail_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAIL) |=> (out_valid_q && out_q.last && state_q == ST_IDLE))
		else $error("tail word missing or not marked last");
`endif

endmodule

/* dv/tb_chunk_reorder_window_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chunk_reorder_window_top
// Self-checking bench for the chunk reorder window. Store and end words are
// driven through the start/busy handshake. A behavioural copy of the window
// predicts every released chunk and status word, and each strobed result is
// checked field by field against the oldest prediction. Directed cases come
// first, then a full-window burst, then random traffic under three idle
// patterns with a different chunk size in each phase.
// ----------------------------------------------------------------------------
module tb_chunk_reorder_window_top;
	import crw_pkg::*;

	localparam int WIN         = 64;    // window depth; slot arithmetic below is 6-bit
	localparam int STALL_LIMIT = 4000;  // cycles with no word moving before giving up
	localparam int DRAIN_WAIT  = 8;     // margin after the last predicted word is back

	logic        clk;
	logic        arst_n;
	logic        start;
	in_word_t    cmd;
	logic        busy;
	logic        result_valid;
	out_word_t   result;
	logic        cfg_we;
	logic [SIZE_W-1:0] cfg_wdata;

	// Behavioural copy of the window state
	logic [SIZE_W-1:0] chunk_size;
	logic [NUM_W-1:0]  win_base;
	logic [5:0]        front;
	logic              occ [WIN];
	logic [PAY_W-1:0]  slot_pay [WIN];
	logic [6:0]        held_cnt;
	logic [PAY_W-1:0]  short_pay;
	logic [SIZE_W-1:0] short_bytes;
	logic [NUM_W-1:0]  short_num;
	logic              short_held;
	logic              end_armed;

	out_word_t due_words [$];   // predicted result words, oldest first
	int        errors = 0;
	int        gap_pct;         // chance in a hundred that the sender pauses
	int        stall_cycles = 0;

	chunk_reorder_window_top #(.WINDOW(WIN)) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (cmd),
		.busy        (busy),
		.result_valid(result_valid),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	always #2 clk = ~clk;

	// Work out the words that one input releases and queue them.
	function automatic void predict_release(input in_word_t w);
		logic [NUM_W-1:0] ofs;
		logic [5:0]       s;
		logic             acc;
		int               run;
		out_word_t        r;
		acc = 1'b1;
		if (w.action == ACT_STORE) begin
			ofs = w.chunk_number - win_base;   // modular distance, wraps at 2^24
			if (ofs < WIN) begin
				if (w.byte_count != chunk_size) begin
					// any other size is the final short chunk; a newer one replaces it
					short_pay   = w.payload;
					short_bytes = w.byte_count;
					short_num   = w.chunk_number;
					short_held  = 1'b1;
				end else begin
					s = front + ofs[5:0];
					slot_pay[s] = w.payload;
					if (!occ[s]) begin
						occ[s]   = 1'b1;
						held_cnt = held_cnt + 7'd1;
					end
				end
			end else begin
				acc = 1'b0;
			end
		end else begin
			end_armed = 1'b1;
		end

		// release the occupied run at the front, never more than a full window
		for (run = 0; run < WIN; run++) begin
			s = front + 6'(run);
			if (!occ[s])
				break;
			r = '{kind: KIND_FULL, accepted: acc, out_number: win_base + NUM_W'(run),
				out_payload: slot_pay[s], out_bytes: chunk_size, last: 1'b0};
			due_words.push_back(r);
			occ[s] = 1'b0;
		end
		held_cnt = held_cnt - 7'(run);
		win_base = win_base + NUM_W'(run);
		front    = front + 6'(run);

		// short chunk goes only once nothing full is buffered and room is left
		if (run < WIN && end_armed && held_cnt == 0 && short_held) begin
			r = '{kind: KIND_SHORT, accepted: acc, out_number: short_num,
				out_payload: short_pay, out_bytes: short_bytes, last: 1'b0};
			due_words.push_back(r);
			short_held = 1'b0;
			end_armed  = 1'b0;
			run++;
		end

		if (run == 0) begin
			r = '{kind: KIND_STATUS, accepted: acc, out_number: '0,
				out_payload: '0, out_bytes: '0, last: 1'b0};
			due_words.push_back(r);
		end

		// mark the closing word of this input's sequence
		r = due_words.pop_back();
		r.last = 1'b1;
		due_words.push_back(r);
	endfunction

	// Offer one word; hold it until taken, then predict its results.
	task automatic send_word(input in_word_t w);
		if ($urandom_range(99) < gap_pct) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(5)) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		cmd   <= w;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		predict_release(w);
	endtask

	// Drop start and wait until every predicted word has come back.
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (due_words.size() != 0 || busy !== 1'b0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_chunk_size(input logic [SIZE_W-1:0] v);
		wait_drained();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		chunk_size = v;
	endtask

	function automatic in_word_t store_word(input logic [NUM_W-1:0] num,
			input logic [PAY_W-1:0] pay, input logic [SIZE_W-1:0] bytes);
		in_word_t w;
		w.action       = ACT_STORE;
		w.chunk_number = num;
		w.payload      = pay;
		w.byte_count   = bytes;
		return w;
	endfunction

	function automatic in_word_t end_word();
		in_word_t w;
		w.action       = ACT_END;
		w.chunk_number = NUM_W'($urandom);
		w.payload      = {$urandom, $urandom};
		w.byte_count   = SIZE_W'($urandom_range(2047));
		return w;
	endfunction

	// Hand-picked cases at the current (reset) chunk size.
	task automatic test_directed_cases();
		logic [SIZE_W-1:0] full;
		in_word_t          w;
		full = chunk_size;
		send_word(store_word(0, '1, full));             // in order: out at once
		send_word(store_word(2, '0, full));             // gap: buffered
		send_word(store_word(2, 64'h0123_4567_89ab_cdef, full)); // overwrite, no double count
		send_word(store_word(1, 64'h5555_aaaa_5555_aaaa, full)); // fills the gap: 1 and 2 out
		send_word(store_word(3, 64'hdead_beef_0000_0001, 11'd0)); // short chunk, held
		send_word(store_word(NUM_W'(3 + WIN), '1, full));       // just beyond the window: rejected
		send_word(store_word('1, '1, full));            // behind the base: rejected
		send_word(store_word(NUM_W'(3 + WIN - 1), '0, 11'h7ff)); // far edge, short size
		w = end_word();
		w.chunk_number = '1;
		w.payload      = '1;
		w.byte_count   = '1;
		send_word(w);                                   // end releases the short chunk
		send_word(end_word());                          // end with nothing held: stays armed
		send_word(store_word(5, 64'h8000_0000_0000_0001, 11'h7ff)); // released at once
		send_word(store_word(4, 64'hcafe_f00d_cafe_f00d, full));    // buffered behind 3
		send_word(store_word(6, 64'h1111_2222_3333_4444, 11'd1));   // short, held
		send_word(end_word());                          // full chunk still buffered: status
		send_word(store_word(3, 64'h0f0f_0f0f_0f0f_0f0f, full));    // 3, 4 then short
		send_word(store_word(7, 64'h7777, 11'd100));    // short
		send_word(store_word(8, 64'h8888, 11'd200));    // newer short replaces it
		send_word(end_word());
		send_word(store_word(win_base, {$urandom, $urandom}, full));
	endtask

	// Fill a whole window out of order so one store releases WINDOW chunks;
	// the short chunk that is due then waits for the next input.
	task automatic test_full_window();
		logic [NUM_W-1:0] b;
		int               i;
		b = win_base;
		for (i = WIN - 1; i >= 1; i--)
			send_word(store_word(b + NUM_W'(i), {$urandom, $urandom}, chunk_size));
		send_word(store_word(b + NUM_W'(5), {$urandom, $urandom}, chunk_size - 11'd1));
		send_word(end_word());                          // full chunks buffered: armed only
		send_word(store_word(b, {$urandom, $urandom}, chunk_size));
		send_word(end_word());
	endtask

	// Mostly well-formed traffic near the window front, with some noise.
	task automatic test_random_traffic(input int items, input int pct);
		int               i;
		int               p;
		logic [NUM_W-1:0] num;
		logic [SIZE_W-1:0] sz;
		gap_pct = pct;
		for (i = 0; i < items; i++) begin
			p = $urandom_range(99);
			if ($urandom_range(9) == 0)
				num = win_base + NUM_W'($urandom_range(WIN + 8));
			else
				num = win_base + NUM_W'($urandom_range(7));
			if (p < 8) begin
				send_word(end_word());
			end else if (p < 16) begin
				// noise: anywhere in the number space, any size
				send_word(store_word(NUM_W'($urandom), {$urandom, $urandom},
					SIZE_W'($urandom_range(2047))));
			end else if (p < 26) begin
				sz = SIZE_W'($urandom_range(2047));
				send_word(store_word(num, {$urandom, $urandom}, sz));
			end else begin
				send_word(store_word(num, {$urandom, $urandom}, chunk_size));
			end
		end
	endtask

	// Check each strobed word against the oldest prediction.
	task automatic check_field(input string fname, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : check_words
		out_word_t want;
		if (arst_n && result_valid === 1'b1) begin
			if (due_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %0h", $time, result);
				errors++;
			end else begin
				want = due_words.pop_front();
				check_field("kind", want.kind, result.kind);
				check_field("accepted", want.accepted, result.accepted);
				check_field("out_number", want.out_number, result.out_number);
				check_field("out_payload", want.out_payload, result.out_payload);
				check_field("out_bytes", want.out_bytes, result.out_bytes);
				check_field("last", want.last, result.last);
			end
		end
	end

	// Watchdog: count cycles in which no word moves in either direction.
	always @(posedge clk) begin
		if (!arst_n || (start && busy === 1'b0) || result_valid === 1'b1)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog expired, %0d words outstanding", $time, due_words.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = '0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		gap_pct      = 0;

		chunk_size  = CHUNK_SIZE_RST;
		win_base    = '0;
		front       = '0;
		occ         = '{default: 1'b0};
		held_cnt    = '0;
		short_pay   = '0;
		short_bytes = '0;
		short_num   = '0;
		short_held  = 1'b0;
		end_armed   = 1'b0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		write_chunk_size(11'h7ff);
		test_full_window();
		write_chunk_size(11'd1);
		test_random_traffic(60, 20);
		write_chunk_size(SIZE_W'($urandom_range(2, 2046)));
		test_random_traffic(60, 51);
		write_chunk_size(CHUNK_SIZE_RST);
		test_random_traffic(60, 0);
		wait_drained();

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
